/* hdl/apc_pkg.sv */
// ----------------------------------------------------------------------------
// Alpha premultiply converter package
// Shared types and constants for the pixel conversion pipeline.
// ----------------------------------------------------------------------------
package apc_pkg;

    typedef enum logic [1:0] {
        MODE_SWAP     = 2'd0,
        MODE_UNPREMUL = 2'd1,
        MODE_PREMUL   = 2'd2
    } apc_mode_t;

    localparam int NUM_CH     = 3;
    localparam int NUM_STAGES = 4;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0]  BYTE_MAX     = 8'hff;
    localparam logic [15:0] ROUND_HALF   = 16'd128;

    typedef struct packed {
        logic                         div_en;
        logic [NUM_CH-1:0]            sat;
        logic [NUM_CH-1:0][7:0]       res;
        logic [NUM_CH-1:0][15:0]      acc;
        logic [7:0]                   alpha;
        logic                         row_end;
    } apc_pipe_t;

endpackage

/* hdl/apc_div_step.sv */
// ----------------------------------------------------------------------------
// Alpha premultiply converter division step
// Two restoring division steps of a colour value by alpha.
// ----------------------------------------------------------------------------
module apc_div_step
    import apc_pkg::*;
(
    input  logic [15:0] acc_in,
    input  logic [7:0]  alpha,
    output logic [15:0] acc_out
);

    always_comb
    begin
        logic [15:0] acc;
        logic [8:0]  trial;
        logic [8:0]  diff;
        acc = acc_in;
        for (int i = 0; i < 2; i++)
        begin
            trial = acc[15:7];
            diff  = trial - {1'b0, alpha};
            if (trial >= {1'b0, alpha})
            begin
                acc = {diff[7:0], acc[6:0], 1'b1};
            end
            else
            begin
                acc = {acc[14:0], 1'b0};
            end
        end
        acc_out = acc;
    end

endmodule

/* hdl/alpha_premultiply_converter_top.sv */
// ----------------------------------------------------------------------------
// Alpha premultiply converter
// Swaps, (un)premultiplies one RGBA8888 pixel per clock while not stalled.
// ----------------------------------------------------------------------------
//  Channel  Handshake           Payload
//  input    in_valid/in_stall   in_byte0..2, in_alpha, row_end
//  output   out_valid/out_stall out_byte0..2, out_alpha, out_row_end
//  config   cfg_we              cfg_data (conversion mode)
//
// A pixel passes five register stages, the four pipeline registers and the
// output register; one pixel enters every cycle while in_stall is low. The
// depth is set by the eight-step restoring division, two steps per stage.
// Reset clears all valid bits and sets the mode to swap. A stall on the output
// only holds stages that are full; empty stages keep filling.
// ----------------------------------------------------------------------------
module alpha_premultiply_converter_top
    import apc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte0,
    input  logic [7:0] in_byte1,
    input  logic [7:0] in_byte2,
    input  logic [7:0] in_alpha,
    input  logic       row_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte0,
    output logic [7:0] out_byte1,
    output logic [7:0] out_byte2,
    output logic [7:0] out_alpha,
    output logic       out_row_end
);

    logic [1:0]              mode_reg;
    logic [NUM_STAGES:0]     valid_reg;
    logic [NUM_STAGES:0]     adv;
    apc_pipe_t               pipe_reg [NUM_STAGES];
    apc_pipe_t               pipe_next [NUM_STAGES];
    logic [NUM_CH-1:0][15:0] acc_step [NUM_STAGES];
    logic [NUM_CH-1:0][7:0]  obyte_reg;
    logic [NUM_CH-1:0][7:0]  obyte_next;
    logic [7:0]              oalpha_reg;
    logic                    orow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SWAP;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    always_comb
    begin
        adv[NUM_STAGES] = !valid_reg[NUM_STAGES] || !out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        logic [NUM_CH-1:0][7:0] chan;
        logic [15:0]            prod;
        chan[0] = in_byte2;
        chan[1] = in_byte1;
        chan[2] = in_byte0;
        pipe_next[0].div_en  = (mode_reg == MODE_UNPREMUL) && (in_alpha != 8'd0)
                               && (in_alpha != ALPHA_OPAQUE);
        pipe_next[0].alpha   = in_alpha;
        pipe_next[0].row_end = row_end;
        for (int c = 0; c < NUM_CH; c++)
        begin
            pipe_next[0].acc[c] = {chan[c], 8'd0} - {8'd0, chan[c]};
            pipe_next[0].sat[c] = chan[c] >= in_alpha;
            prod = 16'(chan[c]) * 16'(in_alpha) + ROUND_HALF;
            pipe_next[0].res[c] = chan[c];
            if (mode_reg == MODE_PREMUL)
            begin
                if (in_alpha == 8'd0)
                begin
                    pipe_next[0].res[c] = 8'd0;
                end
                else if (in_alpha != ALPHA_OPAQUE)
                begin
                    pipe_next[0].res[c] = prod[15:8];
                end
            end
        end
        if ((mode_reg == MODE_PREMUL) && (in_alpha == 8'd0))
        begin
            pipe_next[0].alpha = 8'd0;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            pipe_next[k]     = pipe_reg[k-1];
            pipe_next[k].acc = acc_step[k-1];
        end
    end

    genvar s, ch;
    generate
        for (s = 0; s < NUM_STAGES; s++)
        begin : g_stage
            for (ch = 0; ch < NUM_CH; ch++)
            begin : g_chan
                apc_div_step u_div_step (
                    .acc_in  (pipe_reg[s].acc[ch]),
                    .alpha   (pipe_reg[s].alpha),
                    .acc_out (acc_step[s][ch])
                );
            end
        end
    endgenerate

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (!pipe_reg[NUM_STAGES-1].div_en)
            begin
                obyte_next[c] = pipe_reg[NUM_STAGES-1].res[c];
            end
            else if (pipe_reg[NUM_STAGES-1].sat[c])
            begin
                obyte_next[c] = BYTE_MAX;
            end
            else
            begin
                obyte_next[c] = acc_step[NUM_STAGES-1][c][7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            pipe_reg[0] <= pipe_next[0];
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k] && valid_reg[k-1])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (adv[NUM_STAGES] && valid_reg[NUM_STAGES-1])
        begin
            obyte_reg  <= obyte_next;
            oalpha_reg <= pipe_reg[NUM_STAGES-1].alpha;
            orow_reg   <= pipe_reg[NUM_STAGES-1].row_end;
        end
    end

    assign out_valid   = valid_reg[NUM_STAGES];
    assign out_byte0   = obyte_reg[0];
    assign out_byte1   = obyte_reg[1];
    assign out_byte2   = obyte_reg[2];
    assign out_alpha   = oalpha_reg;
    assign out_row_end = orow_reg;

`ifndef SYNTH
    a_bubble_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0] |-> !in_stall)
        else $error("input stalled although the first stage is empty");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && out_stall) |-> in_stall)
        else $error("transaction accepted into a full stalled pipeline");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[1] && pipe_reg[1].div_en) |->
        ((pipe_reg[1].sat[0] || (pipe_reg[1].acc[0][15:8] < pipe_reg[1].alpha))
         && (pipe_reg[1].sat[1] || (pipe_reg[1].acc[1][15:8] < pipe_reg[1].alpha))
         && (pipe_reg[1].sat[2] || (pipe_reg[1].acc[2][15:8] < pipe_reg[1].alpha))))
        else $error("division remainder not below alpha");
`endif

endmodule

/* test/pixel_conversion_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel conversion checker
// Watches the mode register writes and both pixel channels of the alpha
// premultiply converter. Every accepted input transaction is converted with
// the mode currently in force and queued. Every accepted output transaction
// is compared field by field with the oldest queued pixel.
// ----------------------------------------------------------------------------
module pixel_conversion_checker
    import apc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte0,
    input  logic [7:0] in_byte1,
    input  logic [7:0] in_byte2,
    input  logic [7:0] in_alpha,
    input  logic       row_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte0,
    input  logic [7:0] out_byte1,
    input  logic [7:0] out_byte2,
    input  logic [7:0] out_alpha,
    input  logic       out_row_end,
    output int         mismatch_count,
    output int         pending_pixels
);

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    apc_mode_t active_mode;
    pixel_t    expected_pixels[$];
    int        errors = 0;
    int        queued = 0;

    assign mismatch_count = errors;
    assign pending_pixels = queued;

    function automatic logic [7:0] unpremultiply_byte(logic [7:0] c, logic [7:0] a);
        int unsigned q;
        q = (255 * int'(c)) / int'(a);
        return (q > 255) ? BYTE_MAX : q[7:0];
    endfunction

    function automatic logic [7:0] premultiply_byte(logic [7:0] c, logic [7:0] a);
        int unsigned p;
        p = (int'(c) * int'(a) + 128) >> 8;
        return p[7:0];
    endfunction

    function automatic pixel_t convert_pixel(apc_mode_t mode, pixel_t px);
        pixel_t res;
        res.byte0 = px.byte2;
        res.byte1 = px.byte1;
        res.byte2 = px.byte0;
        res.alpha = px.alpha;
        res.last  = px.last;
        if (mode == MODE_UNPREMUL && px.alpha != 8'd0 && px.alpha != ALPHA_OPAQUE)
        begin
            res.byte0 = unpremultiply_byte(px.byte2, px.alpha);
            res.byte1 = unpremultiply_byte(px.byte1, px.alpha);
            res.byte2 = unpremultiply_byte(px.byte0, px.alpha);
        end
        else if (mode == MODE_PREMUL && px.alpha == 8'd0)
        begin
            res.byte0 = 8'd0;
            res.byte1 = 8'd0;
            res.byte2 = 8'd0;
            res.alpha = 8'd0;
        end
        else if (mode == MODE_PREMUL && px.alpha != ALPHA_OPAQUE)
        begin
            res.byte0 = premultiply_byte(px.byte2, px.alpha);
            res.byte1 = premultiply_byte(px.byte1, px.alpha);
            res.byte2 = premultiply_byte(px.byte0, px.alpha);
        end
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        errors++;
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s is 0x%02h, expected 0x%02h", field, got, want));
    endtask

    task automatic check_result(input pixel_t got);
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            report_error("output transaction with no pixel outstanding");
            return;
        end
        want = expected_pixels.pop_front();
        compare_field("out_byte0", got.byte0, want.byte0);
        compare_field("out_byte1", got.byte1, want.byte1);
        compare_field("out_byte2", got.byte2, want.byte2);
        compare_field("out_alpha", got.alpha, want.alpha);
        compare_field("out_row_end", {7'd0, got.last}, {7'd0, want.last});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_mode = MODE_SWAP;
            expected_pixels.delete();
            queued <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_pixels.push_back(convert_pixel(active_mode,
                    '{in_byte0, in_byte1, in_byte2, in_alpha, row_end}));
            if (out_valid && !out_stall)
                check_result('{out_byte0, out_byte1, out_byte2, out_alpha, out_row_end});
            if (cfg_we)
                active_mode = apc_mode_t'(cfg_data);
            queued <= expected_pixels.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha premultiply converter testbench
// Drives directed and random pixels through all three conversion modes with
// bursty input traffic and a patterned output stall, including long output
// hold-offs. A checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
    import apc_pkg::*;
();

    localparam int  SETTLE_CYCLES    = 16;
    localparam int  LONG_HOLD_CYCLES = 150;
    localparam int  PHASE_PIXELS     = 255;
    localparam time RUN_LIMIT        = 3_000_000;
    localparam apc_mode_t PHASE_MODES [6] = '{MODE_UNPREMUL, MODE_PREMUL, MODE_SWAP,
                                              MODE_PREMUL, MODE_UNPREMUL, MODE_SWAP};

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_alpha;
    logic       row_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_alpha;
    logic       out_row_end;
    logic       hold_req;
    int         mismatch_count;
    int         pending_pixels;
    int         burst_left;

    alpha_premultiply_converter_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte0    (in_byte0),
        .in_byte1    (in_byte1),
        .in_byte2    (in_byte2),
        .in_alpha    (in_alpha),
        .row_end     (row_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte0   (out_byte0),
        .out_byte1   (out_byte1),
        .out_byte2   (out_byte2),
        .out_alpha   (out_alpha),
        .out_row_end (out_row_end)
    );

    pixel_conversion_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte0       (in_byte0),
        .in_byte1       (in_byte1),
        .in_byte2       (in_byte2),
        .in_alpha       (in_alpha),
        .row_end        (row_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte0      (out_byte0),
        .out_byte1      (out_byte1),
        .out_byte2      (out_byte2),
        .out_alpha      (out_alpha),
        .out_row_end    (out_row_end),
        .mismatch_count (mismatch_count),
        .pending_pixels (pending_pixels)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic idle_cycles(input int n);
        in_valid <= 1'b0;
        repeat (n)
        begin
            in_byte0 <= 8'($urandom);
            in_byte1 <= 8'($urandom);
            in_byte2 <= 8'($urandom);
            in_alpha <= 8'($urandom);
            row_end  <= 1'($urandom);
            @(posedge clk);
        end
    endtask

    task automatic send_pixel(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] a,
                              input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 10));
        end
        burst_left--;
        in_valid <= 1'b1;
        in_byte0 <= b0;
        in_byte1 <= b1;
        in_byte2 <= b2;
        in_alpha <= a;
        row_end  <= last;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        idle_cycles(1);
        while (pending_pixels != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_mode(input apc_mode_t mode);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_directed_set();
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(8'hff, 8'h80, 8'h01, 8'h00, 1'b0);
        send_pixel(8'h01, 8'h02, 8'h03, 8'h01, 1'b0);
        send_pixel(8'hff, 8'hfe, 8'h00, 8'hfe, 1'b1);
        send_pixel(8'h40, 8'hc8, 8'h80, 8'h80, 1'b0);
        send_pixel(8'h0a, 8'h14, 8'h7f, 8'h7f, 1'b1);
        send_pixel(8'haa, 8'h55, 8'h0f, 8'hf0, 1'b0);
    endtask

    task automatic send_random_pixel();
        logic [7:0] a;
        logic [7:0] limit;
        case ($urandom_range(0, 9))
            0:       a = 8'h00;
            1:       a = 8'hff;
            2:       a = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'hfe;
            default: a = 8'($urandom);
        endcase
        limit = ($urandom_range(0, 9) < 7) ? a : 8'hff;
        send_pixel(8'($urandom_range(0, limit)), 8'($urandom_range(0, limit)),
                   8'($urandom_range(0, limit)), a, $urandom_range(0, 5) == 0);
    endtask

    initial
    begin
        int seg_left;
        int stall_pct;
        int hold_left;
        bit hold_armed;
        out_stall  = 1'b0;
        seg_left   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        hold_armed = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_armed)
            begin
                hold_armed = 1'b1;
                hold_left  = LONG_HOLD_CYCLES;
            end
            else if (!hold_req)
                hold_armed = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(4, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 25;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = MODE_SWAP;
        in_valid   = 1'b0;
        in_byte0   = 8'h00;
        in_byte1   = 8'h00;
        in_byte2   = 8'h00;
        in_alpha   = 8'h00;
        row_end    = 1'b0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        send_directed_set();
        write_mode(MODE_UNPREMUL);
        send_directed_set();
        write_mode(MODE_PREMUL);
        send_directed_set();

        for (int p = 0; p < 6; p++)
        begin
            write_mode(PHASE_MODES[p]);
            hold_req <= (p == 0 || p == 3);
            repeat (PHASE_PIXELS)
                send_random_pixel();
        end

        drain_results();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
